[rtl/core/qrs_pkg.sv]
// Package for the quadratic root solver: widths, status codes, pipeline types.
// No dependencies.
`timescale 1ns / 1ps
package qrs_pkg;
  localparam int DataWidth = 32;
  localparam int FracBits  = 16;
  localparam int MagW      = DataWidth;          // magnitude of one coefficient
  localparam int ProdW     = 2 * MagW;           // product of two magnitudes
  localparam int DiscW     = ProdW + 3;          // b^2 + 4|ac| with margin
  localparam int RootW     = (DiscW + 1) / 2;    // integer sqrt width
  localparam int QqW       = RootW + 1;          // |2q| = |b| + sqrt(d)
  localparam int NumW      = QqW + FracBits + 1; // widest dividend
  localparam int DenW      = QqW + 1;            // widest divisor

  typedef enum logic [1:0] {
    ST_TWO    = 2'd0,
    ST_DOUBLE = 2'd1,
    ST_NONE   = 2'd2,
    ST_DIVZ   = 2'd3
  } status_t;

  typedef struct packed {
    logic [NumW-1:0] num;
    logic [DenW-1:0] den;
    logic            neg;
  } div_req_t;
endpackage

[rtl/core/qrs_if.sv]
// Valid/ready channel interface with a packed payload.
// Depends on nothing.
`timescale 1ns / 1ps
interface qrs_if #(parameter int W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/quadratic_root_solver_unit.sv]
// Top level of the quadratic root solver: a fully pipelined datapath.
// Depends on qrs_pkg, qrs_if and qrs_isqrt_stage.
`timescale 1ns / 1ps
//  channel | dir | payload                                   | handshake
//  in_     | in  | coef_a, coef_b, coef_c (32 b signed each) | valid/ready
//  out_    | out | root_first, root_second, status, saturated| valid/ready
//
// One word enters per cycle unless the output stalls. The pipeline has one
// sign/magnitude stage, one multiply stage, one discriminant stage, one stage
// per square-root bit (34), one setup stage and one stage per quotient bit (52)
// of the two side-by-side dividers, then a saturation stage. Reset (rst_n low,
// synchronous) clears only the valid bits. A stall at the output freezes every
// stage together, so no word is lost or repeated; the input is ready whenever
// the last stage can move.
module quadratic_root_solver_unit import qrs_pkg::*; (
  input logic clk,
  input logic rst_n,
  qrs_if.sink   in_ch,
  qrs_if.source out_ch
);
  localparam int IsqN = RootW;
  localparam int DivN = NumW;
  localparam int NS   = 4 + IsqN + DivN + 1; // total stages

  // The pipeline advances as one when the output is free.
  logic adv;
  logic [NS-1:0] vld_r;
  assign adv         = !vld_r[NS-1] || out_ch.ready;
  assign in_ch.ready = adv;

  // Stage 0: split into sign and magnitude.
  logic [MagW-1:0] ma_r, mb_r, mc_r;
  logic            na_r, nb_r, nc_r;
  logic [DataWidth-1:0] ia, ib, ic;
  assign ia = in_ch.data[3*DataWidth-1 -: DataWidth];
  assign ib = in_ch.data[2*DataWidth-1 -: DataWidth];
  assign ic = in_ch.data[DataWidth-1:0];
  always_ff @(posedge clk) begin
    if (adv) begin
      na_r <= ia[DataWidth-1]; ma_r <= ia[DataWidth-1] ? MagW'(-ia) : ia;
      nb_r <= ib[DataWidth-1]; mb_r <= ib[DataWidth-1] ? MagW'(-ib) : ib;
      nc_r <= ic[DataWidth-1]; mc_r <= ic[DataWidth-1] ? MagW'(-ic) : ic;
    end
  end

  // Stage 1: products.
  logic [ProdW-1:0] b2_r, ac_r;
  logic [MagW-1:0]  ma1_r, mb1_r, mc1_r;
  logic             na1_r, nb1_r, nc1_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      b2_r <= mb_r * mb_r; ac_r <= ma_r * mc_r;
      ma1_r <= ma_r; mb1_r <= mb_r; mc1_r <= mc_r;
      na1_r <= na_r; nb1_r <= nb_r; nc1_r <= nc_r;
    end
  end

  // Stage 2: discriminant and case.
  logic [DiscW-1:0] disc_r;
  status_t          st2_r;
  logic [MagW-1:0]  ma2_r, mb2_r, mc2_r;
  logic             na2_r, nb2_r, nc2_r;
  logic [DiscW-1:0] b2x, ac4x;
  logic             acn;
  assign b2x  = DiscW'(b2_r);
  assign ac4x = DiscW'({ac_r, 2'b00});
  assign acn  = (na1_r ^ nc1_r) && (ac_r != '0);
  always_ff @(posedge clk) begin
    if (adv) begin
      ma2_r <= ma1_r; mb2_r <= mb1_r; mc2_r <= mc1_r;
      na2_r <= na1_r; nb2_r <= nb1_r; nc2_r <= nc1_r;
      if (acn) begin
        disc_r <= b2x + ac4x; st2_r <= ST_TWO;
      end else if (b2x < ac4x) begin
        disc_r <= '0; st2_r <= ST_NONE;
      end else if (b2x == ac4x) begin
        disc_r <= '0; st2_r <= ST_DOUBLE;
      end else begin
        disc_r <= b2x - ac4x; st2_r <= ST_TWO;
      end
    end
  end

  // Square-root stages, one root bit each.
  logic [DiscW-1:0]   sq_rem_r  [IsqN+1];
  logic [RootW-1:0]   sq_root_r [IsqN+1];
  logic [2*RootW-1:0] sq_rad_r  [IsqN+1];
  status_t            sq_st_r   [IsqN+1];
  logic [MagW-1:0]    sq_ma_r [IsqN+1], sq_mb_r [IsqN+1], sq_mc_r [IsqN+1];
  logic               sq_na_r [IsqN+1], sq_nb_r [IsqN+1], sq_nc_r [IsqN+1];
  always_comb begin
    sq_rem_r[0]  = '0; sq_root_r[0] = '0;
    sq_rad_r[0]  = (2*RootW)'(disc_r); sq_st_r[0] = st2_r;
    sq_ma_r[0] = ma2_r; sq_mb_r[0] = mb2_r; sq_mc_r[0] = mc2_r;
    sq_na_r[0] = na2_r; sq_nb_r[0] = nb2_r; sq_nc_r[0] = nc2_r;
  end
  for (genvar g = 0; g < IsqN; g++) begin : g_sq
    logic [DiscW-1:0]   rem_nxt;
    logic [RootW-1:0]   root_nxt;
    logic [2*RootW-1:0] rad_nxt;
    qrs_isqrt_stage u_stage (
      .rem_i(sq_rem_r[g]), .root_i(sq_root_r[g]), .rad_i(sq_rad_r[g]),
      .rem_o(rem_nxt), .root_o(root_nxt), .rad_o(rad_nxt));
    always_ff @(posedge clk) begin
      if (adv) begin
        sq_rem_r[g+1] <= rem_nxt; sq_root_r[g+1] <= root_nxt;
        sq_rad_r[g+1] <= rad_nxt; sq_st_r[g+1] <= sq_st_r[g];
        sq_ma_r[g+1] <= sq_ma_r[g]; sq_mb_r[g+1] <= sq_mb_r[g];
        sq_mc_r[g+1] <= sq_mc_r[g];
        sq_na_r[g+1] <= sq_na_r[g]; sq_nb_r[g+1] <= sq_nb_r[g];
        sq_nc_r[g+1] <= sq_nc_r[g];
      end
    end
  end

  // Setup stage: build both division requests.
  // Distinct roots: first = 2q*2^F / 2a, second = c*2^(F+1) / 2q.
  // Double root: first = b*2^F / 2a, copied to second.
  div_req_t rq0_nxt, rq1_nxt, rq0_r, rq1_r;
  status_t  st3_nxt, st3_r;
  logic [QqW-1:0] qq;
  logic           qneg;
  logic [MagW-1:0] fa, fb, fc;
  logic            fna, fnb, fnc;
  assign fa = sq_ma_r[IsqN];
  assign fb = sq_mb_r[IsqN];
  assign fc = sq_mc_r[IsqN];
  assign fna = sq_na_r[IsqN];
  assign fnb = sq_nb_r[IsqN];
  assign fnc = sq_nc_r[IsqN];
  assign qq   = QqW'(fb) + QqW'(sq_root_r[IsqN]);
  assign qneg = !fnb && (fb != '0);
  always_comb begin
    rq0_nxt = '0; rq1_nxt = '0; st3_nxt = sq_st_r[IsqN];
    case (sq_st_r[IsqN])
      ST_TWO: begin
        rq1_nxt.num = NumW'({fc, (FracBits+1)'(0)});
        rq1_nxt.den = DenW'(qq);
        rq1_nxt.neg = fnc ^ qneg;
        rq0_nxt.num = NumW'({qq, FracBits'(0)});
        rq0_nxt.den = DenW'({fa, 1'b0});
        rq0_nxt.neg = qneg ^ fna;
        if (fa == '0) st3_nxt = ST_DIVZ;
      end
      ST_DOUBLE: begin
        rq0_nxt.num = NumW'({fb, FracBits'(0)});
        rq0_nxt.den = DenW'({fa, 1'b0});
        rq0_nxt.neg = (fb != '0) && (!fnb ^ fna);
        if (fa == '0) st3_nxt = ST_DIVZ;
      end
      default: ;
    endcase
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      rq0_r <= rq0_nxt; rq1_r <= rq1_nxt; st3_r <= st3_nxt;
    end
  end

  // Two restoring dividers, one quotient bit per stage.
  logic [NumW-1:0] d0_q_r [DivN+1], d1_q_r [DivN+1];
  logic [DenW:0]   d0_m_r [DivN+1], d1_m_r [DivN+1];
  div_req_t        d0_rq_r [DivN+1], d1_rq_r [DivN+1];
  status_t         d_st_r [DivN+1];
  always_comb begin
    d0_q_r[0] = rq0_r.num; d0_m_r[0] = '0; d0_rq_r[0] = rq0_r;
    d1_q_r[0] = rq1_r.num; d1_m_r[0] = '0; d1_rq_r[0] = rq1_r;
    d_st_r[0] = st3_r;
  end
  for (genvar g = 0; g < DivN; g++) begin : g_div
    logic [DenW:0]   t0, t1;
    logic [DenW+1:0] s0, s1;
    assign t0 = {d0_m_r[g][DenW-1:0], d0_q_r[g][NumW-1]};
    assign t1 = {d1_m_r[g][DenW-1:0], d1_q_r[g][NumW-1]};
    assign s0 = {1'b0, t0} - {2'b00, d0_rq_r[g].den};
    assign s1 = {1'b0, t1} - {2'b00, d1_rq_r[g].den};
    always_ff @(posedge clk) begin
      if (adv) begin
        d0_rq_r[g+1] <= d0_rq_r[g]; d1_rq_r[g+1] <= d1_rq_r[g];
        d_st_r[g+1] <= d_st_r[g];
        d0_m_r[g+1] <= s0[DenW+1] ? t0 : s0[DenW:0];
        d0_q_r[g+1] <= {d0_q_r[g][NumW-2:0], !s0[DenW+1]};
        d1_m_r[g+1] <= s1[DenW+1] ? t1 : s1[DenW:0];
        d1_q_r[g+1] <= {d1_q_r[g][NumW-2:0], !s1[DenW+1]};
      end
    end
  end

  // Saturation and output register.
  localparam logic [NumW-1:0] PosLim = NumW'({1'b0, {(DataWidth-1){1'b1}}});
  localparam logic [NumW-1:0] NegLim = NumW'({1'b1, {(DataWidth-1){1'b0}}});
  logic [DataWidth-1:0] r0v, r1v, o0, o1;
  logic s0f, s1f;
  status_t fst;
  logic    osat;
  assign fst = d_st_r[DivN];
  always_comb begin
    logic [NumW-1:0] q, lim;
    q = d0_q_r[DivN]; lim = d0_rq_r[DivN].neg ? NegLim : PosLim;
    s0f = q > lim; if (s0f) q = lim;
    r0v = d0_rq_r[DivN].neg ? DataWidth'(-q) : DataWidth'(q);
    q = d1_q_r[DivN]; lim = d1_rq_r[DivN].neg ? NegLim : PosLim;
    s1f = q > lim; if (s1f) q = lim;
    r1v = d1_rq_r[DivN].neg ? DataWidth'(-q) : DataWidth'(q);
    o0 = '0; o1 = '0; osat = 1'b0;
    case (fst)
      ST_TWO: begin
        o0 = r0v; o1 = r1v; osat = s0f || s1f;
      end
      ST_DOUBLE: begin
        o0 = r0v; o1 = r0v; osat = s0f;
      end
      ST_DIVZ: begin
        if (d1_rq_r[DivN].den != '0) begin
          o1 = r1v; osat = s1f;
        end
      end
      default: ;
    endcase
  end
  logic [2*DataWidth+2:0] out_r;
  always_ff @(posedge clk) begin
    if (adv) out_r <= {o0, o1, fst, osat};
  end
  assign out_ch.data  = out_r;
  assign out_ch.valid = vld_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NS-2:0], in_ch.valid};
    end
  end

  // A stalled output word must hold.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("output word changed under stall");
  // No-root results carry zero roots and no saturation.
  a_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.data[2:1] == ST_NONE |-> out_ch.data[0] == 1'b0)
    else $error("no-root word flagged saturated");
  // Input is accepted whenever the output is free.
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("pipeline blocked with empty output");
endmodule

[rtl/core/qrs_isqrt_stage.sv]
// One bit of a pipelined integer square root (restoring, two bits of radicand a step).
// Depends on qrs_pkg.
`timescale 1ns / 1ps
module qrs_isqrt_stage import qrs_pkg::*; (
  input  logic [DiscW-1:0] rem_i,
  input  logic [RootW-1:0] root_i,
  input  logic [2*RootW-1:0] rad_i,
  output logic [DiscW-1:0] rem_o,
  output logic [RootW-1:0] root_o,
  output logic [2*RootW-1:0] rad_o
);
  logic [DiscW+1:0] trial;
  logic [DiscW+1:0] cur;
  always_comb begin
    cur   = {rem_i, rad_i[2*RootW-1 -: 2]};
    trial = {{(DiscW+2-RootW-2){1'b0}}, root_i, 2'b01};
    rad_o = {rad_i[2*RootW-3:0], 2'b00};
    if (cur >= trial) begin
      rem_o  = DiscW'(cur - trial);
      root_o = {root_i[RootW-2:0], 1'b1};
    end else begin
      rem_o  = DiscW'(cur);
      root_o = {root_i[RootW-2:0], 1'b0};
    end
  end
endmodule
